// ===== sv/bfnc_pkg.sv =====
package bfnc_pkg;

    localparam int NV_MAX    = 8;
    localparam int VW        = 3;
    localparam int PW        = 4;
    localparam int DW        = 48;
    localparam int WW        = 32;
    localparam int IDS_W     = 36;
    localparam int LEN_W     = 4;
    localparam int EDGE_W    = 2 * VW + WW;
    localparam logic [PW-1:0] NONE_VTX = 4'hF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic CFG_NUM_VERTICES = 1'b0;
    localparam logic CFG_NUM_EDGES    = 1'b1;

    typedef struct packed {
        logic run_init;
        logic lat_a;
        logic lat_b;
        logic relax_upd;
        logic walk_init;
        logic walk_step;
        logic trace_init;
        logic trace_step;
        logic push_cycle;
        logic push_final;
    } cmd_t;

    typedef struct packed {
        logic            run_skip;
        logic            rel;
        logic            seen_b;
        logic            walk_bad;
        logic            tr_closed;
        logic            tr_end;
        logic            out_free;
        logic            pend_valid;
        logic [PW-1:0]   nv_eff;
    } sts_t;

endpackage

// ===== sv/bellman_ford_negative_cycle_core.sv =====
// negative cycle detector over a graph of up to eight vertices. a load item (tuser low)
// writes one edge into the edge store. a run item (tuser high) resets distances,
// relaxes edges 0..num_edges-1 num_vertices-1 times, then checks every edge once more;
// each edge that still relaxes onto an unseen vertex starts a parent walk and, if the
// walk stays on valid parents, a trace, and the cycle goes out newest vertex first with
// the closing vertex repeated. a run whose source vertex is out of range or that has no
// edges skips straight to its final result. one result per cycle found, tlast on the
// final one; a run with none gives one result with tuser low. each edge visit is four
// steps of the controller (edge store read, source distance read, saturating add with
// destination read, compare and update) through the single distance read port. no new
// item is accepted until the run has handed its final result to the output register.
module bellman_ford_negative_cycle_core #(
    parameter int MAX_EDGES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // edge_index[5:0], edge_src[8:6], edge_dst[11:9], edge_weight[43:12],
    // source_vertex[46:44], zero fill
    input  logic [47:0] s_tdata,
    // op
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cycle_vertices[35:0], cycle_length[39:36]
    output logic [39:0] m_tdata,
    // found
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata
);
    import bfnc_pkg::*;

    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    cmd_t           cmd;
    sts_t           sts;
    logic [ECW-1:0] edge_cnt;
    logic [ECW-1:0] ne_eff;
    logic           idle;
    logic           in_acc;
    logic [IDS_W-1:0] out_ids;
    logic [LEN_W-1:0] out_len;

    assign s_tready = idle;
    assign in_acc   = s_tvalid && idle;
    assign m_tdata  = {out_len, out_ids};

    bfnc_ctrl #(
        .ECW (ECW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_start (in_acc && (s_tuser == OP_RUN)),
        .ne_eff    (ne_eff),
        .sts       (sts),
        .cmd       (cmd),
        .edge_cnt  (edge_cnt),
        .idle      (idle)
    );

    bfnc_datapath #(
        .MAX_EDGES (MAX_EDGES),
        .ECW       (ECW),
        .AW        (AW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .edge_cnt   (edge_cnt),
        .ne_eff     (ne_eff),
        .load_en    (in_acc && (s_tuser == OP_LOAD)),
        .ld_index   (s_tdata[5:0]),
        .ld_src     (s_tdata[8:6]),
        .ld_dst     (s_tdata[11:9]),
        .ld_weight  (s_tdata[43:12]),
        .run_source (s_tdata[46:44]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_found  (m_tuser),
        .out_ids    (out_ids),
        .out_len    (out_len),
        .out_last   (m_tlast)
    );

endmodule

// ===== sv/bfnc_ctrl.sv =====
module bfnc_ctrl #(
    parameter int ECW = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              run_start,
    input  logic [ECW-1:0]    ne_eff,
    input  bfnc_pkg::sts_t    sts,
    output bfnc_pkg::cmd_t    cmd,
    output logic [ECW-1:0]    edge_cnt,
    output logic              idle
);
    import bfnc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_EA    = 4'd2;
    localparam logic [3:0] S_EB    = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_TRI   = 4'd6;
    localparam logic [3:0] S_TRACE = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]     state_reg, state_next;
    logic [ECW-1:0] e_reg, e_next;
    logic [PW-1:0]  pass_reg, pass_next;
    logic [PW-1:0]  wcnt_reg, wcnt_next;
    logic           final_pass;
    logic           go_next;

    assign final_pass = (pass_reg == sts.nv_eff - 4'd1);
    assign edge_cnt   = e_reg;
    assign idle       = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        pass_next  = pass_reg;
        wcnt_next  = wcnt_reg;
        cmd        = '0;
        go_next    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (run_start)
                begin
                    cmd.run_init = 1'b1;
                    e_next       = '0;
                    pass_next    = '0;
                    state_next   = sts.run_skip ? S_FIN : S_RD;
                end
            end
            S_RD:
                state_next = S_EA;
            S_EA:
            begin
                cmd.lat_a  = 1'b1;
                state_next = S_EB;
            end
            S_EB:
            begin
                cmd.lat_b  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!final_pass)
                begin
                    cmd.relax_upd = 1'b1;
                    go_next       = 1'b1;
                end
                else if (sts.rel && !sts.seen_b)
                begin
                    cmd.walk_init = 1'b1;
                    wcnt_next     = '0;
                    state_next    = S_WALK;
                end
                else
                    go_next = 1'b1;
            end
            S_WALK:
            begin
                if (sts.walk_bad)
                    go_next = 1'b1;
                else
                begin
                    cmd.walk_step = 1'b1;
                    if (wcnt_reg == sts.nv_eff - 4'd1)
                        state_next = S_TRI;
                    else
                        wcnt_next = wcnt_reg + 4'd1;
                end
            end
            S_TRI:
            begin
                cmd.trace_init = 1'b1;
                state_next     = S_TRACE;
            end
            S_TRACE:
            begin
                cmd.trace_step = 1'b1;
                if (sts.tr_closed)
                    state_next = S_EMIT;
                else if (sts.tr_end)
                    go_next = 1'b1;
            end
            S_EMIT:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.push_cycle = 1'b1;
                    go_next        = 1'b1;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.push_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (go_next)
        begin
            state_next = S_RD;
            if (e_reg == ne_eff - {{(ECW-1){1'b0}}, 1'b1})
            begin
                e_next = '0;
                if (final_pass)
                    state_next = S_FIN;
                else
                    pass_next = pass_reg + 4'd1;
            end
            else
                e_next = e_reg + {{(ECW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            e_reg     <= '0;
            pass_reg  <= '0;
            wcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            pass_reg  <= pass_next;
            wcnt_reg  <= wcnt_next;
        end
    end

endmodule

// ===== sv/bfnc_datapath.sv =====
module bfnc_datapath #(
    parameter int MAX_EDGES = 64,
    parameter int ECW       = 7,
    parameter int AW        = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfnc_pkg::cmd_t          cmd,
    output bfnc_pkg::sts_t          sts,
    input  logic [ECW-1:0]          edge_cnt,
    output logic [ECW-1:0]          ne_eff,
    input  logic                    load_en,
    input  logic [5:0]              ld_index,
    input  logic [bfnc_pkg::VW-1:0] ld_src,
    input  logic [bfnc_pkg::VW-1:0] ld_dst,
    input  logic [bfnc_pkg::WW-1:0] ld_weight,
    input  logic [bfnc_pkg::VW-1:0] run_source,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [6:0]              cfg_wdata,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_found,
    output logic [bfnc_pkg::IDS_W-1:0] out_ids,
    output logic [bfnc_pkg::LEN_W-1:0] out_len,
    output logic                    out_last
);
    import bfnc_pkg::*;

    logic [EDGE_W-1:0]  mem [MAX_EDGES];
    logic [EDGE_W-1:0]  rd_data_reg;

    logic [3:0]         nv_cfg_reg;
    logic [6:0]         ne_cfg_reg;
    logic [PW-1:0]      nv_eff;

    logic signed [DW-1:0] dist_reg [NV_MAX];
    logic [NV_MAX-1:0]    dvalid_reg;
    logic [PW-1:0]        parent_reg [NV_MAX];
    logic [NV_MAX-1:0]    seen_reg;

    logic [VW-1:0]        a_reg, b_reg;
    logic [WW-1:0]        w_reg;
    logic                 inr_reg;
    logic signed [DW-1:0] da_reg, db_reg, sum_reg;
    logic                 va_reg, vb_reg;
    logic signed [DW:0]   sum_full;
    logic signed [DW-1:0] sum_sat;
    logic [VW-1:0]        mem_a, mem_b, rd_vtx;

    logic [VW-1:0]        c_reg, k_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [IDS_W-1:0]     ids_reg;
    logic [PW-1:0]        par_c, par_k;

    logic                 pend_valid_reg;
    logic [IDS_W-1:0]     pend_ids_reg;
    logic [LEN_W-1:0]     pend_len_reg;
    logic                 out_free;

    // clamped register values
    always_comb
    begin
        if (nv_cfg_reg == 4'd0)
            nv_eff = 4'd1;
        else if (nv_cfg_reg > 4'(NV_MAX))
            nv_eff = 4'(NV_MAX);
        else
            nv_eff = nv_cfg_reg;
        if (ne_cfg_reg > 7'(MAX_EDGES))
            ne_eff = ECW'(MAX_EDGES);
        else
            ne_eff = ECW'(ne_cfg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_cfg_reg <= 4'(NV_MAX);
            ne_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_VERTICES)
                nv_cfg_reg <= cfg_wdata[3:0];
            else
                ne_cfg_reg <= cfg_wdata;
        end
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (load_en && (7'(ld_index) < 7'(MAX_EDGES)))
            mem[ld_index[AW-1:0]] <= {ld_src, ld_dst, ld_weight};
        rd_data_reg <= mem[edge_cnt[AW-1:0]];
    end

    assign mem_a  = rd_data_reg[EDGE_W-1 -: VW];
    assign mem_b  = rd_data_reg[WW +: VW];
    assign rd_vtx = cmd.lat_b ? b_reg : mem_a;

    assign sum_full = {da_reg[DW-1], da_reg} + (DW+1)'(signed'(w_reg));
    always_comb
    begin
        if (sum_full[DW] != sum_full[DW-1])
            sum_sat = sum_full[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            sum_sat = sum_full[DW-1:0];
    end

    assign par_c = parent_reg[c_reg];
    assign par_k = parent_reg[k_reg];

    assign sts.rel = inr_reg && va_reg && (!vb_reg || (sum_reg < db_reg));
    assign sts.seen_b = seen_reg[b_reg];
    assign sts.walk_bad = (par_c >= nv_eff);
    assign sts.tr_closed = (k_reg == c_reg) && (len_reg != '0);
    assign sts.tr_end = (par_k >= nv_eff) || (len_reg >= nv_eff);
    assign sts.run_skip = (4'(run_source) >= nv_eff) || (ne_eff == '0);
    assign sts.out_free = out_free;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.nv_eff = nv_eff;

    // relaxation datapath
    always_ff @(posedge clk)
    begin
        if (cmd.lat_a)
        begin
            a_reg   <= mem_a;
            b_reg   <= mem_b;
            w_reg   <= rd_data_reg[WW-1:0];
            inr_reg <= (4'(mem_a) < nv_eff) && (4'(mem_b) < nv_eff);
            da_reg  <= dist_reg[rd_vtx];
            va_reg  <= dvalid_reg[rd_vtx];
        end
        if (cmd.lat_b)
        begin
            sum_reg <= sum_sat;
            db_reg  <= dist_reg[rd_vtx];
            vb_reg  <= dvalid_reg[rd_vtx];
        end
        if (cmd.walk_init)
            c_reg <= b_reg;
        else if (cmd.walk_step)
            c_reg <= par_c[VW-1:0];
        if (cmd.trace_init)
        begin
            k_reg   <= c_reg;
            len_reg <= '0;
            ids_reg <= '0;
        end
        else if (cmd.trace_step)
        begin
            k_reg   <= par_k[VW-1:0];
            len_reg <= len_reg + 4'd1;
            ids_reg <= {ids_reg[IDS_W-PW-1:0], 1'b0, k_reg};
        end
        if (cmd.run_init)
            dist_reg[run_source] <= '0;
        else if (cmd.relax_upd && sts.rel)
            dist_reg[b_reg] <= sum_reg;
    end

    // vertex state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvalid_reg <= '0;
            seen_reg   <= '0;
            for (int i = 0; i < NV_MAX; i++)
                parent_reg[i] <= NONE_VTX;
        end
        else if (cmd.run_init)
        begin
            dvalid_reg <= {{(NV_MAX-1){1'b0}}, 1'b1} << run_source;
            seen_reg   <= '0;
            for (int i = 0; i < NV_MAX; i++)
                parent_reg[i] <= NONE_VTX;
        end
        else
        begin
            if (cmd.relax_upd && sts.rel)
            begin
                dvalid_reg[b_reg] <= 1'b1;
                parent_reg[b_reg] <= {1'b0, a_reg};
            end
            if (cmd.trace_step)
                seen_reg[k_reg] <= 1'b1;
        end
    end

    // result holding: one found cycle waits until it is known whether it is the last
    assign out_free = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_init)
                pend_valid_reg <= 1'b0;
            else if (cmd.push_cycle)
                pend_valid_reg <= 1'b1;
            else if (cmd.push_final)
                pend_valid_reg <= 1'b0;
            if ((cmd.push_cycle && pend_valid_reg) || cmd.push_final)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_cycle)
        begin
            pend_ids_reg <= ids_reg;
            pend_len_reg <= len_reg;
            if (pend_valid_reg)
            begin
                out_found <= 1'b1;
                out_ids   <= pend_ids_reg;
                out_len   <= pend_len_reg;
                out_last  <= 1'b0;
            end
        end
        else if (cmd.push_final)
        begin
            out_found <= pend_valid_reg;
            out_ids   <= pend_valid_reg ? pend_ids_reg : '0;
            out_len   <= pend_valid_reg ? pend_len_reg : '0;
            out_last  <= 1'b1;
        end
    end

endmodule

// ===== sv/bfnc_checker.sv =====
module bfnc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a found cycle holds at least the closing pair and at most nine ids
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[39:36] >= 4'd2 && m_tdata[39:36] <= 4'd9))
        else $error("found cycle length out of range");

    // not-found result is empty and closes the run
    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 40'd0))
        else $error("not-found result malformed");

    // for a two-entry cycle, closing vertex repeated at both ends of the packed ids
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser && m_tdata[39:36] == 4'd2) |-> (m_tdata[3:0] == m_tdata[7:4]))
        else $error("two-entry cycle does not close");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind bellman_ford_negative_cycle_core bfnc_checker u_bfnc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
